// ===== design/wwks_pkg.sv =====
`timescale 1ns / 1ps

package wwks_pkg;

   typedef enum logic [1:0] {
      MODE_BOUNDARY = 2'd0,
      MODE_MATCH    = 2'd1,
      MODE_WORD     = 2'd2
   } mode_type;

   typedef struct packed {
      logic       sel;
      logic       repl;
      logic [2:0] count;
      logic       tail;
      logic [7:0] tail_char;
      logic       tail_valid;
      logic       stream_end;
   } job_type;

   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_I     = 8'h69;
   localparam logic [7:0] CH_D     = 8'h64;
   localparam logic [2:0] FULL_LEN = 3'd7;
   localparam logic [2:0] INT_LEN   = 3'd3;
   localparam logic [2:0] FLOAT_LEN = 3'd5;

   function automatic logic is_delim(input logic [7:0] c);
      return c inside {CH_SPACE, CH_HASH, 8'h28, 8'h29, 8'h3C, 8'h3E, 8'h7B, 8'h7D,
                       8'h5B, 8'h5D, 8'h3B, 8'h2C, CH_NL, CH_TAB};
   endfunction

   function automatic logic [7:0] kw_char(input logic sel, input logic [2:0] idx);
      logic [7:0] ch;
      case ({sel, idx})
         4'b0_000: ch = "i";
         4'b0_001: ch = "n";
         4'b0_010: ch = "t";
         4'b0_011: ch = "e";
         4'b0_100: ch = "g";
         4'b0_101: ch = "e";
         4'b0_110: ch = "r";
         4'b1_000: ch = "d";
         4'b1_001: ch = "e";
         4'b1_010: ch = "c";
         4'b1_011: ch = "i";
         4'b1_100: ch = "m";
         4'b1_101: ch = "a";
         4'b1_110: ch = "l";
         default:  ch = 8'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] repl_char(input logic sel, input logic [2:0] idx);
      logic [7:0] ch;
      case ({sel, idx})
         4'b0_000: ch = "i";
         4'b0_001: ch = "n";
         4'b0_010: ch = "t";
         4'b1_000: ch = "f";
         4'b1_001: ch = "l";
         4'b1_010: ch = "o";
         4'b1_011: ch = "a";
         4'b1_100: ch = "t";
         default:  ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

// ===== design/wwks_front.sv =====
`timescale 1ns / 1ps

module wwks_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        in_char,
   input  logic              stream_end,
   output logic              push,
   output wwks_pkg::job_type job
);

   wwks_pkg::mode_type mode_ff, mode_in;
   logic               sel_ff, sel_in;
   logic [2:0]         len_ff, len_in;

   logic               delim;
   logic               kw_hit;
   logic               start_kw;
   logic               tail_ok;
   logic               flush_sel;
   logic [2:0]         flush_len;
   logic               flush_repl;
   logic               emit_tail;
   logic [7:0]         emit_char;

   assign delim    = wwks_pkg::is_delim(in_char);
   assign kw_hit   = (len_ff != wwks_pkg::FULL_LEN) &&
                     (wwks_pkg::kw_char(sel_ff, len_ff) == in_char);
   assign start_kw = (in_char == wwks_pkg::CH_I) || (in_char == wwks_pkg::CH_D);
   assign tail_ok  = !((in_char == wwks_pkg::CH_NL) && stream_end);

   always_comb begin
      mode_in = mode_ff;
      sel_in  = sel_ff;
      len_in  = len_ff;
      case (mode_ff)
         wwks_pkg::MODE_MATCH: begin
            if (delim) begin
               mode_in = wwks_pkg::MODE_BOUNDARY;
               len_in  = 3'd0;
            end else if (kw_hit) begin
               len_in = len_ff + 3'd1;
            end else begin
               mode_in = wwks_pkg::MODE_WORD;
               len_in  = 3'd0;
            end
         end
         wwks_pkg::MODE_BOUNDARY: begin
            if (delim) begin
               mode_in = wwks_pkg::MODE_BOUNDARY;
            end else if (start_kw) begin
               mode_in = wwks_pkg::MODE_MATCH;
               sel_in  = (in_char == wwks_pkg::CH_D);
               len_in  = 3'd1;
            end else begin
               mode_in = wwks_pkg::MODE_WORD;
            end
         end
         default: begin
            mode_in = delim ? wwks_pkg::MODE_BOUNDARY : wwks_pkg::MODE_WORD;
         end
      endcase
      if (stream_end) begin
         mode_in = wwks_pkg::MODE_BOUNDARY;
         sel_in  = 1'b0;
         len_in  = 3'd0;
      end
   end

   always_comb begin
      flush_sel  = sel_ff;
      flush_len  = 3'd0;
      flush_repl = 1'b0;
      emit_tail  = 1'b0;
      emit_char  = in_char;
      case (mode_ff)
         wwks_pkg::MODE_MATCH: begin
            if (delim) begin
               flush_len  = len_ff;
               flush_repl = 1'b1;
               emit_tail  = tail_ok;
            end else if (kw_hit) begin
               flush_len  = stream_end ? (len_ff + 3'd1) : 3'd0;
               flush_repl = 1'b1;
            end else begin
               flush_len = len_ff;
               emit_tail = 1'b1;
            end
         end
         wwks_pkg::MODE_BOUNDARY: begin
            if (delim) begin
               emit_tail = tail_ok;
            end else if (start_kw) begin
               flush_sel = (in_char == wwks_pkg::CH_D);
               flush_len = stream_end ? 3'd1 : 3'd0;
            end else begin
               emit_tail = 1'b1;
            end
         end
         default: begin
            emit_tail = delim ? tail_ok : 1'b1;
         end
      endcase

      job.sel        = flush_sel;
      job.repl       = flush_repl && (flush_len == wwks_pkg::FULL_LEN);
      job.count      = job.repl ? (flush_sel ? wwks_pkg::FLOAT_LEN : wwks_pkg::INT_LEN)
                                : flush_len;
      job.tail       = emit_tail;
      job.tail_char  = emit_char;
      job.tail_valid = 1'b1;
      job.stream_end = stream_end;
      if (stream_end && (flush_len == 3'd0) && !emit_tail) begin
         job.tail       = 1'b1;
         job.tail_char  = 8'h00;
         job.tail_valid = 1'b0;
      end
      push = accept && ((job.count != 3'd0) || job.tail);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= wwks_pkg::MODE_BOUNDARY;
         sel_ff  <= 1'b0;
         len_ff  <= 3'd0;
      end else if (accept) begin
         mode_ff <= mode_in;
         sel_ff  <= sel_in;
         len_ff  <= len_in;
      end
   end

endmodule

// ===== design/wwks_queue.sv =====
`timescale 1ns / 1ps

module wwks_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  wwks_pkg::job_type push_job,
   input  logic              pop,
   output logic              head_valid,
   output wwks_pkg::job_type head_job,
   output logic              full
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

   wwks_pkg::job_type entry_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_pop;

   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];
   assign full       = (count_ff == DEPTH_C);
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== design/wwks_back.sv =====
`timescale 1ns / 1ps

module wwks_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  wwks_pkg::job_type head_job,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_out_char,
   output logic              rsp_char_valid,
   output logic              rsp_run_last,
   output logic              rsp_stream_done
);

   logic [2:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] char_ff, char_in;
   logic       cvalid_ff, cvalid_in;
   logic       last_ff, last_in;
   logic       done_ff, done_in;

   logic [3:0] total;
   logic       in_flush;
   logic       advance;

   assign total    = {1'b0, head_job.count} + {3'b000, head_job.tail};
   assign in_flush = (idx_ff < head_job.count);
   assign advance  = head_valid && (!valid_ff || !rsp_stall);
   assign last_in  = (({1'b0, idx_ff} + 4'd1) == total);
   assign done_in  = last_in && head_job.stream_end;
   assign pop      = advance && last_in;

   always_comb begin
      if (in_flush) begin
         char_in   = head_job.repl ? wwks_pkg::repl_char(head_job.sel, idx_ff)
                                   : wwks_pkg::kw_char(head_job.sel, idx_ff);
         cvalid_in = 1'b1;
      end else begin
         char_in   = head_job.tail_char;
         cvalid_in = head_job.tail_valid;
      end
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (advance) begin
         idx_in   = last_in ? 3'd0 : idx_ff + 3'd1;
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         char_ff   <= char_in;
         cvalid_ff <= cvalid_in;
         last_ff   <= last_in;
         done_ff   <= done_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_char    = char_ff;
   assign rsp_char_valid  = cvalid_ff;
   assign rsp_run_last    = last_ff;
   assign rsp_stream_done = done_ff;

endmodule

// ===== design/whole_word_keyword_substituter_unit.sv =====
`timescale 1ns / 1ps
// Whole-word keyword substituter.
// Input channel (req_): one text byte per item plus req_stream_end on the last
// byte of a stream. Output channel (rsp_): one byte per item; rsp_run_last marks
// the last item caused by an input byte, rsp_stream_done the last item of a stream.
// A bare end marker (rsp_char_valid low, rsp_out_char zero) closes a stream whose
// final byte produced nothing else.
// The whole words "integer" and "decimal" come out as "int" and "float"; a newline
// as final stream byte is dropped. Bytes of a possible keyword are held back.
// The first output item of an input byte passes through the queue write, then the
// output register. Throughput: one input byte per cycle while each byte gives at
// most one output and rsp_stall is low; a byte that releases N items (up to 8)
// occupies the output sequencer until all N are sent. A QUEUE_DEPTH-entry job
// queue decouples the classifier from the sequencer, so req_stall rises only when
// that queue is full.
// Reset clears the word state, the queue and the output valid bit; no item is
// valid afterwards. When rsp_stall is high the output item holds, the sequencer
// waits and the queue fills, after which req_stall is raised.
module whole_word_keyword_substituter_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_char,
   input  logic       req_stream_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_char_valid,
   output logic       rsp_run_last,
   output logic       rsp_stream_done
);

   logic              accept;
   logic              push;
   wwks_pkg::job_type push_job;
   logic              pop;
   logic              head_valid;
   wwks_pkg::job_type head_job;
   logic              full;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   wwks_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .in_char    (req_in_char),
      .stream_end (req_stream_end),
      .push       (push),
      .job        (push_job)
   );

   wwks_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job),
      .full       (full)
   );

   wwks_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (head_valid),
      .head_job        (head_job),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_char    (rsp_out_char),
      .rsp_char_valid  (rsp_char_valid),
      .rsp_run_last    (rsp_run_last),
      .rsp_stream_done (rsp_stream_done)
   );

`ifndef NO_ASSERTIONS
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stream_done) |-> rsp_run_last)
      else $error("stream_done without run_last");

   a_marker_ends_stream: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_char_valid) |-> (rsp_stream_done && rsp_out_char == 8'h00))
      else $error("bare marker not at stream end");

   a_pop_on_output: assert property (@(posedge clock) disable iff (reset)
      pop |=> (rsp_valid && rsp_run_last))
      else $error("job retired without a run_last item");
`endif

endmodule
